>>> src/iup_pkg.sv
package iup_pkg;

    // Longest supported image line in bytes; sizes the line buffer.
    localparam int LINE_MAX = 8192;
    localparam int ADDR_W = $clog2(LINE_MAX);
    localparam int POS_W = $clog2(LINE_MAX + 1);
    localparam int LINE_BYTES_W = 14;
    localparam int BYTE_W = 8;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [LINE_BYTES_W-1:0] LINE_BYTES_RESET = LINE_BYTES_W'(1920);

    typedef enum logic [1:0] {
        MODE_LEFT  = 2'd0,
        MODE_UP    = 2'd1,
        MODE_AVG   = 2'd2,
        MODE_PAETH = 2'd3
    } mode_t;

    typedef enum logic [0:0] {
        REG_FILTER_MODE = 1'b0,
        REG_LINE_BYTES  = 1'b1
    } reg_idx_t;

    // Which line of the frame we are on; later lines all behave alike.
    typedef enum logic [2:0] {
        ROW_FIRST  = 3'b001,
        ROW_SECOND = 3'b010,
        ROW_LATER  = 3'b100
    } row_t;

    typedef struct packed {
        logic [BYTE_W-1:0] filtered_byte;
        logic              first;
        logic              pass;
        mode_t             mode;
        logic [ADDR_W-1:0] addr;
    } item_t;

    function automatic row_t row_advance(input row_t row);
        row_t nxt;
        unique case (row)
            ROW_FIRST:  nxt = ROW_SECOND;
            ROW_SECOND: nxt = ROW_LATER;
            ROW_LATER:  nxt = ROW_LATER;
            default:    nxt = ROW_FIRST;
        endcase
        return nxt;
    endfunction

    // A length of zero acts as one; lengths above the buffer size are clipped.
    function automatic logic [POS_W-1:0] effective_length(
        input logic [LINE_BYTES_W-1:0] n
    );
        logic [POS_W-1:0] len;
        if (n == '0) begin
            len = POS_W'(1);
        end
        else if (32'(n) > LINE_MAX) begin
            len = POS_W'(LINE_MAX);
        end
        else begin
            len = POS_W'(n);
        end
        return len;
    endfunction

endpackage

>>> src/iup_line_ram.sv
module iup_line_ram #(
    parameter int ADDR_W = 13,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/iup_cfg_regs.sv
module iup_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [iup_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [iup_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [iup_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready,
    output iup_pkg::mode_t                       filter_mode,
    output logic [iup_pkg::LINE_BYTES_W-1:0]     line_bytes
);

    iup_pkg::mode_t                   filter_mode_reg;
    logic [iup_pkg::LINE_BYTES_W-1:0] line_bytes_reg;
    iup_pkg::reg_idx_t                reg_idx;
    logic                             wr_en;

    assign reg_idx = iup_pkg::reg_idx_t'(paddr[2]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_mode_reg <= iup_pkg::MODE_LEFT;
            line_bytes_reg  <= iup_pkg::LINE_BYTES_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                iup_pkg::REG_FILTER_MODE:
                begin
                    filter_mode_reg <= iup_pkg::mode_t'(pwdata[1:0]);
                end
                iup_pkg::REG_LINE_BYTES:
                begin
                    line_bytes_reg <= pwdata[iup_pkg::LINE_BYTES_W-1:0];
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            iup_pkg::REG_FILTER_MODE:
                prdata = iup_pkg::APB_DATA_W'(filter_mode_reg);
            iup_pkg::REG_LINE_BYTES:
                prdata = iup_pkg::APB_DATA_W'(line_bytes_reg);
        endcase
    end

    assign filter_mode = filter_mode_reg;
    assign line_bytes  = line_bytes_reg;

endmodule

>>> src/iup_addr_gen.sv
module iup_addr_gen (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  logic [iup_pkg::BYTE_W-1:0]       filtered_byte,
    input  logic                             first_of_frame,
    input  iup_pkg::mode_t                   filter_mode,
    input  logic [iup_pkg::LINE_BYTES_W-1:0] line_bytes,
    output iup_pkg::item_t                   item,
    output logic [iup_pkg::ADDR_W-1:0]       raddr
);

    logic [iup_pkg::POS_W-1:0] pos_reg;
    logic [iup_pkg::POS_W-1:0] pos_next;
    iup_pkg::row_t             row_reg;
    iup_pkg::row_t             row_next;

    logic [iup_pkg::POS_W-1:0] len;
    logic [iup_pkg::POS_W-1:0] pos_start;
    logic [iup_pkg::POS_W-1:0] pos_cur;
    logic [iup_pkg::POS_W-1:0] pos_inc;
    iup_pkg::row_t             row_start;
    iup_pkg::row_t             row_cur;
    logic                      pos_zero;
    logic                      pass;

    assign len = iup_pkg::effective_length(line_bytes);

    always_comb
    begin
        pos_start = first_of_frame ? '0 : pos_reg;
        row_start = first_of_frame ? iup_pkg::ROW_FIRST : row_reg;

        // A shortened line may leave the column past the end: wrap first.
        if (pos_start >= len)
        begin
            pos_cur = '0;
            row_cur = iup_pkg::row_advance(row_start);
        end
        else
        begin
            pos_cur = pos_start;
            row_cur = row_start;
        end

        pos_inc = pos_cur + iup_pkg::POS_W'(1);
        if (pos_inc >= len)
        begin
            pos_next = '0;
            row_next = iup_pkg::row_advance(row_cur);
        end
        else
        begin
            pos_next = pos_inc;
            row_next = row_cur;
        end
    end

    assign pos_zero = (pos_cur == '0);

    always_comb
    begin
        case (filter_mode)
            iup_pkg::MODE_LEFT:
                pass = (row_cur == iup_pkg::ROW_FIRST) && pos_zero;
            iup_pkg::MODE_UP:
                pass = (row_cur == iup_pkg::ROW_FIRST);
            default:
                pass = (row_cur == iup_pkg::ROW_FIRST) ||
                       ((row_cur == iup_pkg::ROW_SECOND) && pos_zero);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            row_reg <= iup_pkg::ROW_FIRST;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            row_reg <= row_next;
        end
    end

    assign raddr = pos_cur[iup_pkg::ADDR_W-1:0];

    always_comb
    begin
        item.filtered_byte = filtered_byte;
        item.first         = first_of_frame;
        item.pass          = pass;
        item.mode          = filter_mode;
        item.addr          = raddr;
    end

endmodule

>>> src/iup_recon.sv
module iup_recon (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  iup_pkg::item_t              item,
    input  logic [iup_pkg::ADDR_W-1:0]  raddr,
    input  logic [iup_pkg::BYTE_W-1:0]  rdata,
    output logic                        s1_ready,
    output logic                        wr_en,
    output logic [iup_pkg::ADDR_W-1:0]  waddr,
    output logic [iup_pkg::BYTE_W-1:0]  wdata,
    output logic                        pixel_valid,
    input  logic                        pixel_ready,
    output logic [iup_pkg::BYTE_W-1:0]  pixel_byte
);

    iup_pkg::item_t             s1_reg;
    logic                       s1_valid_reg;
    logic                       fwd_hit_reg;
    logic [iup_pkg::BYTE_W-1:0] fwd_data_reg;
    logic [iup_pkg::BYTE_W-1:0] prev_reg;
    logic [iup_pkg::BYTE_W-1:0] ul_reg;
    logic                       pixel_valid_reg;
    logic                       pixel_valid_next;
    logic [iup_pkg::BYTE_W-1:0] pixel_byte_reg;

    logic                       s1_adv;
    logic [iup_pkg::BYTE_W-1:0] left;
    logic [iup_pkg::BYTE_W-1:0] up;
    logic [iup_pkg::BYTE_W-1:0] ul;
    logic [iup_pkg::BYTE_W:0]   sum_lu;
    logic [iup_pkg::BYTE_W:0]   ul_x2;
    logic [iup_pkg::BYTE_W-1:0] dist_left;
    logic [iup_pkg::BYTE_W-1:0] dist_up;
    logic [iup_pkg::BYTE_W:0]   dist_ul;
    logic [iup_pkg::BYTE_W-1:0] paeth;
    logic [iup_pkg::BYTE_W-1:0] pred;
    logic [iup_pkg::BYTE_W-1:0] result;

    assign s1_adv   = s1_valid_reg & (~pixel_valid_reg | pixel_ready);
    assign s1_ready = ~s1_valid_reg | s1_adv;

    // A read of an entry being written returns its old byte; when the byte just
    // written is the one being fetched (one-byte lines), use it directly.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (accept)
        begin
            fwd_hit_reg <= wr_en && (waddr == raddr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_data_reg <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= item;
        end
    end

    assign left = s1_reg.first ? '0 : prev_reg;
    assign ul   = s1_reg.first ? '0 : ul_reg;
    assign up   = fwd_hit_reg ? fwd_data_reg : rdata;

    // Paeth distances: |up-ul|, |left-ul| and |left+up-2*ul|.
    always_comb
    begin
        sum_lu    = {1'b0, left} + {1'b0, up};
        ul_x2     = {ul, 1'b0};
        dist_left = (up >= ul) ? (up - ul) : (ul - up);
        dist_up   = (left >= ul) ? (left - ul) : (ul - left);
        dist_ul   = (sum_lu >= ul_x2) ? (sum_lu - ul_x2) : (ul_x2 - sum_lu);
        if ((dist_left <= dist_up) && ({1'b0, dist_left} <= dist_ul))
        begin
            paeth = left;
        end
        else if ({1'b0, dist_up} <= dist_ul)
        begin
            paeth = up;
        end
        else
        begin
            paeth = ul;
        end
    end

    always_comb
    begin
        case (s1_reg.mode)
            iup_pkg::MODE_LEFT:  pred = left;
            iup_pkg::MODE_UP:    pred = up;
            iup_pkg::MODE_AVG:   pred = sum_lu[iup_pkg::BYTE_W:1];
            default:             pred = paeth;
        endcase
    end

    assign result = s1_reg.pass ? s1_reg.filtered_byte : (s1_reg.filtered_byte + pred);

    assign wr_en = s1_adv;
    assign waddr = s1_reg.addr;
    assign wdata = result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            ul_reg   <= '0;
        end
        else if (s1_adv)
        begin
            prev_reg <= result;
            ul_reg   <= up;
        end
    end

    always_comb
    begin
        if (s1_adv)
        begin
            pixel_valid_next = 1'b1;
        end
        else if (pixel_ready)
        begin
            pixel_valid_next = 1'b0;
        end
        else
        begin
            pixel_valid_next = pixel_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_valid_reg <= 1'b0;
        end
        else
        begin
            pixel_valid_reg <= pixel_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            pixel_byte_reg <= result;
        end
    end

    assign pixel_valid = pixel_valid_reg;
    assign pixel_byte  = pixel_byte_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |-> !accept)
        else $error("reconstruction stage overwritten while stalled");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> pixel_valid_reg)
        else $error("finished byte did not reach the output register");

    a_fwd_follows_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(fwd_hit_reg) |-> $past(wr_en))
        else $error("forwarded line byte without a preceding buffer write");

    a_write_in_order: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (s1_valid_reg && (!pixel_valid_reg || pixel_ready)))
        else $error("line buffer written without a transaction leaving");

endmodule

>>> src/image_unfilter_predictor_core.sv
// Image scanline unfilter with left, up, average and Paeth predictors.
// Filtered bytes enter on the byte channel (byte_valid/byte_ready with
// filtered_byte and first_of_frame); reconstructed bytes leave on the pixel
// channel (pixel_valid/pixel_ready with pixel_byte), one per input byte and
// in the same order. first_of_frame restarts column and line counting.
// The APB port sets filter_mode (offset 0x0) and line_bytes (offset 0x4);
// write them only while no transaction is in flight.
// An accepted byte is registered in the reconstruction stage and then in the
// output register. Throughput is one byte per cycle while the output is not
// stalled, set by the single read-modify-write of the line buffer (one read
// and one write port, read data registered) per byte; a byte whose
// line-above entry is written in the same cycle gets it by forwarding.
// When pixel_ready is low, the output register holds its byte and one more
// byte can be taken into the reconstruction stage; then byte_ready drops.
// Reset clears the position, line count, neighbor bytes and registers
// (filter_mode 0, line_bytes 1920). The line buffer is not cleared; every
// entry used later is written in a frame's first line if lines do not grow.
module image_unfilter_predictor_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               byte_valid,
    output logic                               byte_ready,
    input  logic [iup_pkg::BYTE_W-1:0]         filtered_byte,
    input  logic                               first_of_frame,
    output logic                               pixel_valid,
    input  logic                               pixel_ready,
    output logic [iup_pkg::BYTE_W-1:0]         pixel_byte,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [iup_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [iup_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [iup_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    iup_pkg::mode_t                   filter_mode;
    logic [iup_pkg::LINE_BYTES_W-1:0] line_bytes;
    iup_pkg::item_t                   item;
    logic [iup_pkg::ADDR_W-1:0]       raddr;
    logic [iup_pkg::BYTE_W-1:0]       rdata;
    logic                             s1_ready;
    logic                             accept;
    logic                             wr_en;
    logic [iup_pkg::ADDR_W-1:0]       waddr;
    logic [iup_pkg::BYTE_W-1:0]       wdata;

    assign byte_ready = s1_ready;
    assign accept     = byte_valid & s1_ready;

    iup_cfg_regs u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .filter_mode (filter_mode),
        .line_bytes  (line_bytes)
    );

    iup_addr_gen u_addr (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .filtered_byte  (filtered_byte),
        .first_of_frame (first_of_frame),
        .filter_mode    (filter_mode),
        .line_bytes     (line_bytes),
        .item           (item),
        .raddr          (raddr)
    );

    iup_line_ram #(
        .ADDR_W (iup_pkg::ADDR_W),
        .DATA_W (iup_pkg::BYTE_W)
    ) u_line_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata (wdata),
        .re    (accept),
        .raddr (raddr),
        .rdata (rdata)
    );

    iup_recon u_recon (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (item),
        .raddr       (raddr),
        .rdata       (rdata),
        .s1_ready    (s1_ready),
        .wr_en       (wr_en),
        .waddr       (waddr),
        .wdata       (wdata),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel_byte  (pixel_byte)
    );

endmodule

>>> test/image_unfilter_predictor_core_test.sv
module image_unfilter_predictor_core_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 200;

    typedef logic [iup_pkg::BYTE_W-1:0] byte_row_t [8];

    typedef enum logic [1:0] {
        FLOW_FREE,
        FLOW_HALF,
        FLOW_MOSTLY,
        FLOW_SPARSE
    } flow_t;

    // Mirrors the unfilter datapath and holds the reconstructed bytes still owed.
    class unfilter_scoreboard;
        logic [iup_pkg::BYTE_W-1:0] line_mem [iup_pkg::LINE_MAX];
        logic [iup_pkg::BYTE_W-1:0] left_byte;
        logic [iup_pkg::BYTE_W-1:0] corner_byte;
        int column;
        int written_hi;
        iup_pkg::row_t row;
        iup_pkg::mode_t mode;
        logic [iup_pkg::LINE_BYTES_W-1:0] line_len;
        logic [iup_pkg::BYTE_W-1:0] pending_pixels [$];
        int mismatch_count;

        function new();
            foreach (line_mem[i])
            begin
                line_mem[i] = '0;
            end
            left_byte = '0;
            corner_byte = '0;
            column = 0;
            written_hi = 0;
            row = iup_pkg::ROW_FIRST;
            mode = iup_pkg::MODE_LEFT;
            line_len = iup_pkg::LINE_BYTES_RESET;
            mismatch_count = 0;
        endfunction

        function int span();
            int n;
            n = int'(line_len);
            if (n == 0)
            begin
                n = 1;
            end
            if (n > iup_pkg::LINE_MAX)
            begin
                n = iup_pkg::LINE_MAX;
            end
            return n;
        endfunction

        function void set_register(iup_pkg::reg_idx_t idx,
                                   logic [iup_pkg::APB_DATA_W-1:0] value);
            if (idx == iup_pkg::REG_FILTER_MODE)
            begin
                mode = iup_pkg::mode_t'(value[1:0]);
            end
            else
            begin
                line_len = value[iup_pkg::LINE_BYTES_W-1:0];
            end
        endfunction

        // A longer line in the middle of a frame would read buffer entries never filled.
        function bit needs_frame_start();
            return row != iup_pkg::ROW_FIRST && span() > written_hi;
        endfunction

        function void next_line();
            column = 0;
            if (row == iup_pkg::ROW_FIRST)
            begin
                row = iup_pkg::ROW_SECOND;
            end
            else
            begin
                row = iup_pkg::ROW_LATER;
            end
        endfunction

        function logic [iup_pkg::BYTE_W-1:0] paeth(logic [iup_pkg::BYTE_W-1:0] a,
                                                   logic [iup_pkg::BYTE_W-1:0] b,
                                                   logic [iup_pkg::BYTE_W-1:0] c);
            int est;
            int da;
            int db;
            int dc;
            est = int'(a) + int'(b) - int'(c);
            da = (est > int'(a)) ? est - int'(a) : int'(a) - est;
            db = (est > int'(b)) ? est - int'(b) : int'(b) - est;
            dc = (est > int'(c)) ? est - int'(c) : int'(c) - est;
            if (da <= db && da <= dc)
            begin
                return a;
            end
            if (db <= dc)
            begin
                return b;
            end
            return c;
        endfunction

        function void note_byte(logic [iup_pkg::BYTE_W-1:0] value, logic start);
            int len;
            logic [iup_pkg::BYTE_W-1:0] up;
            logic [iup_pkg::BYTE_W-1:0] pred;
            logic [iup_pkg::BYTE_W-1:0] result;
            bit pass;
            len = span();
            if (start)
            begin
                column = 0;
                row = iup_pkg::ROW_FIRST;
                left_byte = '0;
                corner_byte = '0;
            end
            if (column >= len)
            begin
                next_line();
            end
            up = line_mem[column];
            case (mode)
                iup_pkg::MODE_LEFT:
                begin
                    pass = (row == iup_pkg::ROW_FIRST && column == 0);
                    pred = left_byte;
                end
                iup_pkg::MODE_UP:
                begin
                    pass = (row == iup_pkg::ROW_FIRST);
                    pred = up;
                end
                iup_pkg::MODE_AVG:
                begin
                    pass = (row == iup_pkg::ROW_FIRST) ||
                           (row == iup_pkg::ROW_SECOND && column == 0);
                    pred = iup_pkg::BYTE_W'((int'(left_byte) + int'(up)) / 2);
                end
                default:
                begin
                    pass = (row == iup_pkg::ROW_FIRST) ||
                           (row == iup_pkg::ROW_SECOND && column == 0);
                    pred = paeth(left_byte, up, corner_byte);
                end
            endcase
            result = pass ? value : value + pred;
            corner_byte = up;
            line_mem[column] = result;
            if (column + 1 > written_hi)
            begin
                written_hi = column + 1;
            end
            left_byte = result;
            column++;
            if (column >= len)
            begin
                next_line();
            end
            pending_pixels.push_back(result);
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatch_count++;
        endtask

        task check_pixel(logic [iup_pkg::BYTE_W-1:0] got);
            logic [iup_pkg::BYTE_W-1:0] want;
            if (pending_pixels.size() == 0)
            begin
                report_mismatch($sformatf("pixel_byte %02h with no byte outstanding", got));
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got !== want)
                begin
                    report_mismatch($sformatf("pixel_byte %02h, expected %02h", got, want));
                end
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic byte_valid = 1'b0;
    logic byte_ready;
    logic [iup_pkg::BYTE_W-1:0] filtered_byte = '0;
    logic first_of_frame = 1'b0;
    logic pixel_valid;
    logic pixel_ready = 1'b0;
    logic [iup_pkg::BYTE_W-1:0] pixel_byte;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [iup_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [iup_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [iup_pkg::APB_DATA_W-1:0] prdata;
    logic pready;

    unfilter_scoreboard sb = new();
    int burst_left = 0;
    bit start_pending = 1'b0;
    logic hold_toggle = 1'b0;
    int cycle_count = 0;

    image_unfilter_predictor_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_ready     (byte_ready),
        .filtered_byte  (filtered_byte),
        .first_of_frame (first_of_frame),
        .pixel_valid    (pixel_valid),
        .pixel_ready    (pixel_ready),
        .pixel_byte     (pixel_byte),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && byte_ready)
            begin
                sb.note_byte(filtered_byte, first_of_frame);
            end
            if (pixel_valid && pixel_ready)
            begin
                sb.check_pixel(pixel_byte);
            end
        end
    end

    initial
    begin : receiver
        flow_t flow;
        int flow_left;
        int hold_left;
        logic hold_seen;
        flow = FLOW_FREE;
        flow_left = 0;
        hold_left = 0;
        hold_seen = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_toggle != hold_seen)
            begin
                hold_seen = hold_toggle;
                hold_left = HOLD_CYCLES;
            end
            if (flow_left == 0)
            begin
                flow = flow_t'($urandom_range(0, 3));
                flow_left = $urandom_range(10, 150);
            end
            flow_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                pixel_ready <= 1'b0;
            end
            else
            begin
                case (flow)
                    FLOW_FREE:   pixel_ready <= 1'b1;
                    FLOW_HALF:   pixel_ready <= ($urandom_range(0, 1) == 0);
                    FLOW_MOSTLY: pixel_ready <= ($urandom_range(0, 7) != 0);
                    default:     pixel_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_byte(input logic [iup_pkg::BYTE_W-1:0] value, input logic start);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                byte_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        byte_valid <= 1'b1;
        filtered_byte <= value;
        first_of_frame <= start | start_pending;
        start_pending = 1'b0;
        @(posedge clk);
        while (!byte_ready)
        begin
            @(posedge clk);
        end
    endtask

    // Every byte yields one pixel, so an empty queue means the pipeline is drained.
    task automatic wait_idle();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_pixels.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_register(input iup_pkg::reg_idx_t idx,
                                  input logic [iup_pkg::APB_DATA_W-1:0] value);
        logic [iup_pkg::APB_DATA_W-1:0] readback;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        sb.set_register(idx, value);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (idx == iup_pkg::REG_FILTER_MODE)
        begin
            if (readback[1:0] !== value[1:0])
            begin
                sb.report_mismatch($sformatf("filter_mode reads %0h", readback));
            end
        end
        else if (readback[iup_pkg::LINE_BYTES_W-1:0] !== value[iup_pkg::LINE_BYTES_W-1:0])
        begin
            sb.report_mismatch($sformatf("line_bytes reads %0h", readback));
        end
    endtask

    task automatic configure(input iup_pkg::mode_t mode,
                             input logic [iup_pkg::LINE_BYTES_W-1:0] len);
        wait_idle();
        write_register(iup_pkg::REG_FILTER_MODE, iup_pkg::APB_DATA_W'(mode));
        write_register(iup_pkg::REG_LINE_BYTES, iup_pkg::APB_DATA_W'(len));
        start_pending = sb.needs_frame_start();
    endtask

    task automatic feed_bytes(input byte_row_t values, input int count, input logic start);
        for (int i = 0; i < count; i++)
        begin
            send_byte(values[i], start && i == 0);
        end
    endtask

    function automatic logic [iup_pkg::BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return iup_pkg::BYTE_W'($urandom);
        endcase
    endfunction

    function automatic logic [iup_pkg::LINE_BYTES_W-1:0] pick_length();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return iup_pkg::LINE_BYTES_W'(1);
            2:       return iup_pkg::LINE_BYTES_W'($urandom_range(2, 3));
            default: return iup_pkg::LINE_BYTES_W'($urandom_range(4, 24));
        endcase
    endfunction

    task automatic random_run(input iup_pkg::mode_t mode,
                              input logic [iup_pkg::LINE_BYTES_W-1:0] len,
                              input int count);
        configure(mode, len);
        for (int i = 0; i < count; i++)
        begin
            if (i == 0)
            begin
                send_byte(pick_byte(), $urandom_range(0, 2) == 0);
            end
            else
            begin
                send_byte(pick_byte(), $urandom_range(0, 79) == 0);
            end
        end
    endtask

    initial
    begin : main
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bytes straight after reset continue a frame that began at reset.
        feed_bytes('{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00}, 4, 1'b0);
        configure(iup_pkg::MODE_UP, iup_pkg::LINE_BYTES_W'(3));
        feed_bytes('{8'h10, 8'hF0, 8'h01, 8'hFF, 8'h20, 8'h00, 8'hFE, 8'h81}, 8, 1'b1);
        // A line length of zero behaves as one byte per line.
        configure(iup_pkg::MODE_AVG, '0);
        feed_bytes('{8'h40, 8'h02, 8'hFF, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00}, 4, 1'b1);
        configure(iup_pkg::MODE_PAETH, iup_pkg::LINE_BYTES_W'(2));
        feed_bytes('{8'h00, 8'h00, 8'h00, 8'h00, 8'h05, 8'hFF, 8'h80, 8'h7F}, 8, 1'b1);

        // Oversized lengths are clipped; the frame stays on its first line, and the
        // later shrink starts a new line in the middle of the frame.
        random_run(iup_pkg::MODE_LEFT, '1, 6);
        random_run(iup_pkg::MODE_PAETH, iup_pkg::LINE_BYTES_W'(iup_pkg::LINE_MAX), 20);
        random_run(iup_pkg::MODE_AVG, iup_pkg::LINE_BYTES_W'(5), 40);

        for (int run = 0; run < 10; run++)
        begin
            configure(iup_pkg::mode_t'($urandom_range(0, 3)), pick_length());
            if (run == 2)
            begin
                hold_toggle <= ~hold_toggle;
            end
            for (int i = 0; i < 45; i++)
            begin
                if (i == 0)
                begin
                    send_byte(pick_byte(), $urandom_range(0, 2) == 0);
                end
                else
                begin
                    send_byte(pick_byte(), $urandom_range(0, 79) == 0);
                end
            end
        end

        byte_valid <= 1'b0;
        for (int k = 0; k < 4000 && sb.pending_pixels.size() != 0; k++)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (sb.pending_pixels.size() != 0)
        begin
            sb.report_mismatch($sformatf("%0d pixels never arrived", sb.pending_pixels.size()));
        end
        if (sb.mismatch_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
